FILE: src/spi_command_register_parser_defines.svh
// ---------------------------------------------------------------------------
// SPI command register parser assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SPI_COMMAND_REGISTER_PARSER_DEFINES_SVH
`define SPI_COMMAND_REGISTER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define SCRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define SCRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCRP_ASSERT(lbl, prop, msg)
`define SCRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/scrp_pkg.sv
// ---------------------------------------------------------------------------
// SPI command register parser package
// Parser modes, opcodes, register addresses and register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scrp_pkg;

  localparam int NUM_REGS_DEF = 26;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 6;

  localparam logic [CNT_W-1:0] POS_MAX = 6'd63;

  typedef enum logic [2:0] {
    MODE_COMMAND      = 3'd0,
    MODE_RREG_COUNT   = 3'd1,
    MODE_WREG_COUNT   = 3'd2,
    MODE_RREG_PENDING = 3'd3,
    MODE_WREG_DATA    = 3'd4
  } mode_t;

  localparam logic [7:0] OP_RDATAC = 8'h10;
  localparam logic [7:0] OP_SDATAC = 8'h11;
  localparam logic [7:0] OP_START  = 8'h08;
  localparam logic [7:0] OP_STOP   = 8'h0A;
  localparam logic [7:0] OP_RESET  = 8'h06;
  localparam logic [7:0] OP_RREG   = 8'h20;
  localparam logic [7:0] OP_WREG   = 8'h40;

  localparam logic [7:0] OPC_MASK  = 8'hE0;
  localparam logic [7:0] ARG_MASK  = 8'h1F;

  localparam logic [7:0] ADDR_ID         = 8'h00;
  localparam logic [7:0] ADDR_CONFIG1    = 8'h01;
  localparam logic [7:0] ADDR_CONFIG2    = 8'h02;
  localparam logic [7:0] ADDR_CONFIG3    = 8'h03;
  localparam logic [7:0] ADDR_LOFF_STATP = 8'h12;
  localparam logic [7:0] ADDR_LOFF_STATN = 8'h13;
  localparam logic [7:0] ADDR_GPIO       = 8'h14;

  // register file control from the parser
  typedef struct packed {
    logic             load;    // reload defaults
    logic             wr_en;
    logic [7:0]       addr;
    logic [BYTE_W-1:0] data;
  } rf_ctl_t;

  function automatic logic [BYTE_W-1:0] reg_default(input logic [7:0] addr);
    logic [BYTE_W-1:0] val;
    unique case (addr)
      ADDR_ID:      val = 8'h92;
      ADDR_CONFIG1: val = 8'h06;
      ADDR_CONFIG2: val = 8'h40;
      ADDR_CONFIG3: val = 8'h40;
      ADDR_GPIO:    val = 8'h0F;
      default:      val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

FILE: src/scrp_regfile.sv
// ---------------------------------------------------------------------------
// SPI command register parser register file
// Flop-based register bank with default reload, write filtering and one
// combinational read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrp_regfile #(
  parameter int NUM_REGS = scrp_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scrp_pkg::rf_ctl_t             ctl,
  input  logic [7:0]                    rd_addr,
  output logic [scrp_pkg::BYTE_W-1:0]   rd_data
);
  import scrp_pkg::*;

  localparam int         IDX_W   = $clog2(NUM_REGS);
  localparam logic [7:0] LIMIT_B = 8'(NUM_REGS);

  logic [BYTE_W-1:0] regs_r [NUM_REGS];
  logic              ro_hit;
  logic              wr_ok;

  // ID and lead-off status are read only
  assign ro_hit = (ctl.addr == ADDR_ID) || (ctl.addr == ADDR_LOFF_STATP) ||
                  (ctl.addr == ADDR_LOFF_STATN);
  assign wr_ok  = ctl.wr_en && !ro_hit && (ctl.addr < LIMIT_B);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.load) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= reg_default(8'(i));
      end
    end else if (wr_ok) begin
      regs_r[ctl.addr[IDX_W-1:0]] <= ctl.data;
    end
  end

  assign rd_data = (rd_addr < LIMIT_B) ? regs_r[rd_addr[IDX_W-1:0]] : '0;

endmodule

FILE: src/spi_command_register_parser.sv
// ---------------------------------------------------------------------------
// SPI command register parser
// Byte-level command decoder and register file of an ADC SPI port.
// ---------------------------------------------------------------------------
// Takes one received SPI byte per beat and returns one beat per byte: the byte
// shifted back at that position plus the continuous-read and conversion flags
// as they stand after the byte. Throughput is one beat per clock: decode,
// register-file access and state update all complete in the accept cycle and
// land in a single output register, whose beat is offered in the next cycle;
// the input is stalled only while that register holds a beat the sink refuses.
// Opcodes: RDATAC/SDATAC set/clear continuous read, START/STOP set/clear the
// conversion flag, RESET reloads register defaults and clears both flags.
// RREG/WREG carry a base address and take a count byte (low five bits + 1).
// WREG data goes to incrementing addresses; ID, LOFF_STATP, LOFF_STATN and
// addresses past the file are skipped. An RREG answer is sent in the next
// transaction (beat flagged first_of_transaction); its incoming bytes are
// ignored, and positions past the count or the file return zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "spi_command_register_parser_defines.svh"

module spi_command_register_parser #(
  parameter int NUM_REGS = scrp_pkg::NUM_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // received bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_of_transaction
  // returned bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] tx_byte, [8] continuous_read_on,
                                  // [9] conversion_started, [15:10] zero
);
  import scrp_pkg::*;

  // parser state
  mode_t              mode_r,  mode_nxt;
  logic [7:0]         ptr_r,   ptr_nxt;   // RREG/WREG address pointer
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;   // remaining / answer count
  logic               ans_r,   ans_nxt;   // answering transaction
  logic [CNT_W-1:0]   pos_r,   pos_nxt;   // answer position
  logic               cont_r,  cont_nxt;
  logic               run_r,   run_nxt;

  // output beat
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_tx_r,    out_tx_nxt;
  logic               out_cont_r;
  logic               out_run_r;

  logic               accept;
  logic [7:0]         b;
  mode_t              mode_v;
  logic               ans_v;
  logic [CNT_W-1:0]   pos_v;
  logic [7:0]         rd_addr;
  logic [BYTE_W-1:0]  rd_data;
  rf_ctl_t            rf_ctl;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;

  // answer address: base plus position, wraps at 8 bits
  assign rd_addr = ptr_r + {2'b00, pos_v};

  // transaction boundary: a pending RREG turns it into an answer
  always_comb begin
    mode_v = mode_r;
    ans_v  = ans_r;
    pos_v  = pos_r;
    if (in_tuser && mode_r == MODE_RREG_PENDING) begin
      ans_v  = 1'b1;
      pos_v  = '0;
      mode_v = MODE_COMMAND;
    end else if (in_tuser) begin
      ans_v  = 1'b0;
    end
  end

  always_comb begin
    ptr_nxt  = ptr_r;
    cnt_nxt  = cnt_r;
    cont_nxt = cont_r;
    run_nxt  = run_r;
    out_tx_nxt = '0;
    rf_ctl   = '{load: 1'b0, wr_en: 1'b0, addr: ptr_r, data: b};

    mode_nxt = mode_v;
    ans_nxt  = ans_v;
    pos_nxt  = pos_v;

    if (ans_v) begin
      out_tx_nxt = (pos_v < cnt_r) ? rd_data : '0;
      if (pos_v < POS_MAX) begin
        pos_nxt = pos_v + 1'b1;
      end
    end else begin
      unique case (mode_v)
        MODE_COMMAND: begin
          priority if (b == OP_RDATAC) begin
            cont_nxt = 1'b1;
          end else if (b == OP_SDATAC) begin
            cont_nxt = 1'b0;
          end else if (b == OP_START) begin
            run_nxt = 1'b1;
          end else if (b == OP_STOP) begin
            run_nxt = 1'b0;
          end else if (b == OP_RESET) begin
            rf_ctl.load = 1'b1;
            cont_nxt    = 1'b0;
            run_nxt     = 1'b0;
          end else if ((b & OPC_MASK) == OP_RREG) begin
            ptr_nxt  = b & ARG_MASK;
            mode_nxt = MODE_RREG_COUNT;
          end else if ((b & OPC_MASK) == OP_WREG) begin
            ptr_nxt  = b & ARG_MASK;
            mode_nxt = MODE_WREG_COUNT;
          end else begin
            // unknown command byte: no effect
          end
        end
        MODE_RREG_COUNT: begin
          cnt_nxt  = {1'b0, b[4:0]} + 1'b1;
          mode_nxt = MODE_RREG_PENDING;
        end
        MODE_WREG_COUNT: begin
          cnt_nxt  = {1'b0, b[4:0]} + 1'b1;
          mode_nxt = MODE_WREG_DATA;
        end
        MODE_WREG_DATA: begin
          rf_ctl.wr_en = 1'b1;
          ptr_nxt      = ptr_r + 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            mode_nxt = MODE_COMMAND;
          end
        end
        default: begin
          // extra byte after an RREG count cancels the answer
          mode_nxt = MODE_COMMAND;
        end
      endcase
    end

    // register file acts only on accepted beats
    rf_ctl.load  = rf_ctl.load  && accept;
    rf_ctl.wr_en = rf_ctl.wr_en && accept;

    out_valid_nxt = accept || (out_valid_r && !out_tready);
  end

  scrp_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rf_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_COMMAND;
      ptr_r       <= '0;
      cnt_r       <= '0;
      ans_r       <= 1'b0;
      pos_r       <= '0;
      cont_r      <= 1'b0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
        ptr_r  <= ptr_nxt;
        cnt_r  <= cnt_nxt;
        ans_r  <= ans_nxt;
        pos_r  <= pos_nxt;
        cont_r <= cont_nxt;
        run_r  <= run_nxt;
      end
    end
  end

  // output payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      out_tx_r   <= out_tx_nxt;
      out_cont_r <= cont_nxt;
      out_run_r  <= run_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_run_r, out_cont_r, out_tx_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SCRP_ASSERT(a_ans_in_cmd, ans_r |-> mode_r == MODE_COMMAND, "answering outside command mode")
  `SCRP_ASSERT(a_ans_cnt, ans_r |-> cnt_r != '0, "answering with zero count")
  `SCRP_ASSERT(a_wdata_cnt, (mode_r == MODE_WREG_DATA) |-> cnt_r != '0, "WREG data zero count")
  `SCRP_ASSERT(a_no_overrun, (out_valid_r && !out_tready) |-> !in_tready, "accept over held beat")
  `SCRP_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid_r && !ans_r, "state not cleared by reset")

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// SPI command register parser testbench
// Streams received SPI bytes into the parser and checks every returned beat
// (shifted-back byte plus continuous-read and conversion flags) against a
// cycle-free software model of the command decoder and register file, or typed-in values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scrp_pkg::*;

  localparam int REG_COUNT   = NUM_REGS_DEF;
  localparam int ITEM_TARGET = 900;
  localparam int IDLE_PCT    = 36;
  localparam int WDOG_LIMIT  = 2000;
  localparam int DRAIN_CYC   = 8;

  // one returned beat as the sink sees it
  typedef struct packed {
    logic [7:0] tx;
    logic       cont;
    logic       run;
  } reply_t;

  // directed row: byte, first-of-transaction, typed-in expectation if any
  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       typed;
    logic [7:0] tx;
    logic       cont;
    logic       run;
  } stim_row_t;

  localparam stim_row_t DIRECTED [26] = '{
    // RREG of ID/CONFIG1/CONFIG2, answer in next transaction, then past count
    '{OP_RREG | ADDR_ID,         1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
    '{8'h02,                     1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    '{8'hFF,                     1'b1, 1'b1, 8'h92, 1'b0, 1'b0},
    '{8'h00,                     1'b0, 1'b1, 8'h06, 1'b0, 1'b0},
    '{8'h00,                     1'b0, 1'b1, 8'h40, 1'b0, 1'b0},
    '{8'h00,                     1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    // flags on
    '{OP_RDATAC,                 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
    '{OP_START,                  1'b0, 1'b1, 8'h00, 1'b1, 1'b1},
    // write to read-only ID is dropped
    '{OP_WREG | ADDR_ID,         1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
    '{8'h00,                     1'b0, 1'b1, 8'h00, 1'b1, 1'b1},
    '{8'hFF,                     1'b0, 1'b1, 8'h00, 1'b1, 1'b1},
    // LOFF_STATP/LOFF_STATN skipped, GPIO written; count byte high bits set
    '{OP_WREG | ADDR_LOFF_STATP, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hE2,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hAA,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h55,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hA5,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // last register, then one past the file; count crosses a CS boundary
    '{OP_WREG | 8'(REG_COUNT-1), 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01,                     1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h7E,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h33,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // RREG at top address, max count, extra byte cancels the answer
    '{OP_RREG | ARG_MASK,        1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h1F,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h99,                     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // flags off, register reload
    '{OP_STOP,                   1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
    '{OP_SDATAC,                 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    '{OP_RESET,                  1'b0, 1'b1, 8'h00, 1'b0, 1'b0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  reply_t      reply_q[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned quiet_cyc  = 0;
  bit          calm       = 1'b0;   // both sides run without gaps

  // parser state as the model keeps it
  mode_t       p_mode;
  logic [7:0]  p_ptr;
  logic [5:0]  p_count;
  logic        p_answering;
  logic [5:0]  p_pos;
  logic [7:0]  p_regs [REG_COUNT];
  logic        p_cont;
  logic        p_run;

  spi_command_register_parser #(
    .NUM_REGS(REG_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic load_register_defaults();
    for (int i = 0; i < REG_COUNT; i++) p_regs[i] = 8'h00;
    p_regs[ADDR_ID]      = 8'h92;
    p_regs[ADDR_CONFIG1] = 8'h06;
    p_regs[ADDR_CONFIG2] = 8'h40;
    p_regs[ADDR_CONFIG3] = 8'h40;
    p_regs[ADDR_GPIO]    = 8'h0F;
  endtask

  task automatic clear_parser();
    p_mode      = MODE_COMMAND;
    p_ptr       = 8'h00;
    p_count     = '0;
    p_answering = 1'b0;
    p_pos       = '0;
    p_cont      = 1'b0;
    p_run       = 1'b0;
    load_register_defaults();
  endtask

  // advance the parser by one received byte, return the beat it sends back
  task automatic parse_spi_byte(input logic [7:0] b, input logic first, output reply_t r);
    logic [7:0] ra;
    logic       ro;
    r = '0;
    if (first && p_mode == MODE_RREG_PENDING) begin
      p_answering = 1'b1;
      p_pos       = '0;
      p_mode      = MODE_COMMAND;
    end else if (first) begin
      p_answering = 1'b0;
    end

    if (p_answering) begin
      ra = p_ptr + 8'(p_pos);
      if (p_pos < p_count && ra < REG_COUNT) r.tx = p_regs[ra];
      if (p_pos != POS_MAX) p_pos = p_pos + 6'd1;
    end else begin
      case (p_mode)
        MODE_COMMAND: begin
          if (b == OP_RDATAC) p_cont = 1'b1;
          else if (b == OP_SDATAC) p_cont = 1'b0;
          else if (b == OP_START) p_run = 1'b1;
          else if (b == OP_STOP) p_run = 1'b0;
          else if (b == OP_RESET) begin
            load_register_defaults();
            p_cont = 1'b0;
            p_run  = 1'b0;
          end else if ((b & OPC_MASK) == OP_RREG) begin
            p_ptr  = b & ARG_MASK;
            p_mode = MODE_RREG_COUNT;
          end else if ((b & OPC_MASK) == OP_WREG) begin
            p_ptr  = b & ARG_MASK;
            p_mode = MODE_WREG_COUNT;
          end
        end
        MODE_RREG_COUNT: begin
          p_count = 6'(b & ARG_MASK) + 6'd1;
          p_mode  = MODE_RREG_PENDING;
        end
        MODE_WREG_COUNT: begin
          p_count = 6'(b & ARG_MASK) + 6'd1;
          p_mode  = MODE_WREG_DATA;
        end
        MODE_WREG_DATA: begin
          ro = (p_ptr == ADDR_ID || p_ptr == ADDR_LOFF_STATP || p_ptr == ADDR_LOFF_STATN);
          if (p_ptr < REG_COUNT && !ro) p_regs[p_ptr] = b;
          p_ptr   = p_ptr + 8'd1;
          p_count = p_count - 6'd1;
          if (p_count == '0) p_mode = MODE_COMMAND;
        end
        // extra byte after an RREG count drops the pending answer
        default: p_mode = MODE_COMMAND;
      endcase
    end
    r.cont = p_cont;
    r.run  = p_run;
  endtask

  // drive one byte, hold until accepted, queue what it must send back
  task automatic send_beat(input logic [7:0] b, input logic first,
                           input logic typed, input reply_t want);
    reply_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_spi_byte(b, first, pred);
    reply_q.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    send_beat(b, first, 1'b0, '0);
  endtask

  // count byte: mostly short runs, random don't-care upper bits
  function automatic logic [7:0] pick_count();
    logic [4:0] n;
    n = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    return {3'($urandom_range(0, 7)), n};
  endfunction

  // sink: compare every returned beat, stall at random
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected beat: tdata %h", out_tdata);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_tdata[7:0] !== want.tx) begin
            $error("tx_byte: expected %h, actual %h", want.tx, out_tdata[7:0]);
            mismatches++;
          end
          if (out_tdata[8] !== want.cont) begin
            $error("continuous_read_on: expected %b, actual %b", want.cont, out_tdata[8]);
            mismatches++;
          end
          if (out_tdata[9] !== want.run) begin
            $error("conversion_started: expected %b, actual %b", want.run, out_tdata[9]);
            mismatches++;
          end
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    int         kind;
    int         n;
    int         len;
    logic [7:0] cnt_byte;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].b, DIRECTED[i].first, DIRECTED[i].typed,
                '{DIRECTED[i].tx, DIRECTED[i].cont, DIRECTED[i].run});

    // random command sequences, a stretch in the middle without gaps
    while (beats_sent < ITEM_TARGET) begin
      calm = (beats_sent >= 400 && beats_sent < 560);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        case ($urandom_range(0, 4))
          0: send_byte(OP_RDATAC, 1'b1);
          1: send_byte(OP_SDATAC, 1'b1);
          2: send_byte(OP_START, 1'b1);
          3: send_byte(OP_STOP, 1'b1);
          default: send_byte(OP_RESET, 1'b1);
        endcase
      end else if (kind < 50) begin
        // register write burst, occasionally split across chip selects
        send_byte(OP_WREG | 8'($urandom_range(0, 31)), 1'b1);
        cnt_byte = pick_count();
        send_byte(cnt_byte, $urandom_range(0, 99) < 5);
        n = int'(cnt_byte & ARG_MASK) + 1;
        for (int k = 0; k < n; k++)
          send_byte(8'($urandom), $urandom_range(0, 99) < 5);
      end else if (kind < 85) begin
        send_byte(OP_RREG | 8'($urandom_range(0, 31)), 1'b1);
        cnt_byte = pick_count();
        send_byte(cnt_byte, $urandom_range(0, 99) < 5);
        n = int'(cnt_byte & ARG_MASK) + 1;
        len = $urandom_range(0, 99);
        if (len < 10) begin
          // stray byte in the same transaction
          send_byte(8'($urandom), 1'b0);
        end else begin
          // long answers drive the position counter into saturation
          len = (len < 14) ? $urandom_range(60, 70) : $urandom_range(1, n + 3);
          send_byte(8'($urandom), 1'b1);
          for (int k = 1; k < len; k++) send_byte(8'($urandom), 1'b0);
        end
      end else begin
        send_byte(8'($urandom), 1'($urandom));
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
